// ===== sv/dpd_pkg.sv =====
// Shared types and constants for the depth packet deframer.
// Result item layout, parser phase codes and configuration register indexes.
package dpd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  localparam logic [1:0] CFG_MAGIC      = 2'd0;
  localparam logic [1:0] CFG_START_TYPE = 2'd1;
  localparam logic [1:0] CFG_END_TYPE   = 2'd2;

  typedef struct packed {
    logic [15:0] magic_word;
    logic [15:0] start_type;
    logic [15:0] end_type;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_byte;
    logic [31:0] frame_time;
    logic        last;
  } result_t;

endpackage

// ===== sv/dpd_parse.sv =====
// Byte parser of the depth packet deframer: magic hunt, header decode, payload pass.
// Produces up to two result items per byte. Depends on dpd_pkg.
module dpd_parse #(
  parameter int HEADER_BYTES = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            mode_i,
  input  logic [7:0]      data_byte_i,
  input  dpd_pkg::cfg_t   cfg_i,
  output logic [1:0]      res_cnt_o,
  output dpd_pkg::result_t res0_o,
  output dpd_pkg::result_t res1_o
);
  import dpd_pkg::*;

  localparam int CntW = $clog2(HEADER_BYTES);

  phase_e          phase_q, phase_d;
  logic            magic_lo_q, magic_lo_d;
  logic [CntW-1:0] hcnt_q, hcnt_d;
  logic [15:0]     left_q, left_d;
  logic [15:0]     pkind_q, pkind_d;
  logic [31:0]     ptime_q, ptime_d;
  logic [15:0]     prev_id_q, prev_id_d;
  logic            id_seen_q, id_seen_d;
  logic            open_q, open_d;
  logic            bad_q, bad_d;

  logic [7:0]      hdr_q [HEADER_BYTES];
  logic [7:0]      hdr_v [HEADER_BYTES];
  logic            hdr_we;
  logic [CntW-1:0] hdr_idx;
  logic [7:0]      hdr_wdata;
  logic            magic_we;

  logic [15:0]     id;
  logic [15:0]     size;
  logic            fin;
  logic [1:0]      n;
  result_t         res [2];

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hdr_v[i] = (i == HEADER_BYTES - 1) ? data_byte_i : hdr_q[i];
    end
  end

  assign id   = {hdr_v[5], hdr_v[4]};
  assign size = {hdr_v[6], hdr_v[7]};

  always_comb begin
    phase_d    = phase_q;
    magic_lo_d = magic_lo_q;
    hcnt_d     = hcnt_q;
    left_d     = left_q;
    pkind_d    = pkind_q;
    ptime_d    = ptime_q;
    prev_id_d  = prev_id_q;
    id_seen_d  = id_seen_q;
    open_d     = open_q;
    bad_d      = bad_q;
    hdr_we     = 1'b0;
    hdr_idx    = hcnt_q;
    hdr_wdata  = data_byte_i;
    magic_we   = 1'b0;
    fin        = 1'b0;
    n          = 2'd0;
    res[0]     = '0;
    res[1]     = '0;

    if (mode_i) begin
      bad_d      = 1'b1;
      phase_d    = PH_HUNT;
      magic_lo_d = 1'b0;
      hcnt_d     = '0;
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          hdr_we = 1'b1;
          hcnt_d = hcnt_q + 1'b1;
          if (hcnt_q == CntW'(HEADER_BYTES - 1)) begin
            pkind_d = {hdr_v[3], hdr_v[2]};
            ptime_d = {hdr_v[11], hdr_v[10], hdr_v[9], hdr_v[8]};
            if (size < 16'(HEADER_BYTES)) begin
              bad_d      = 1'b1;
              phase_d    = PH_HUNT;
              magic_lo_d = 1'b0;
              hcnt_d     = '0;
            end else begin
              if (id_seen_q && id != prev_id_q + 16'd1) begin
                bad_d = 1'b1;
              end
              prev_id_d = id;
              id_seen_d = 1'b1;
              if (pkind_d == cfg_i.start_type) begin
                open_d    = 1'b1;
                bad_d     = 1'b0;
                res[0]    = '{kind: KIND_START, frame_byte: '0, frame_time: '0, last: 1'b0};
                n         = 2'd1;
              end
              left_d  = size - 16'(HEADER_BYTES);
              phase_d = PH_PAYLOAD;
              fin     = (left_d == '0);
            end
          end
        end
        PH_PAYLOAD: begin
          if (open_q && !bad_q) begin
            res[0] = '{kind: KIND_DATA, frame_byte: data_byte_i, frame_time: '0, last: 1'b0};
            n      = 2'd1;
          end
          if (left_q != '0) begin
            left_d = left_q - 16'd1;
          end
          fin = (left_d == '0);
        end
        default: begin
          if (magic_lo_q && data_byte_i == cfg_i.magic_word[15:8]) begin
            magic_lo_d = 1'b0;
            magic_we   = 1'b1;
            hcnt_d     = CntW'(2);
            phase_d    = PH_HEADER;
          end else begin
            phase_d    = PH_HUNT;
            magic_lo_d = (data_byte_i == cfg_i.magic_word[7:0]);
          end
        end
      endcase

      if (fin) begin
        if (pkind_d == cfg_i.end_type) begin
          if (open_d && !bad_d) begin
            res[n[0]] = '{kind: KIND_DONE, frame_byte: '0, frame_time: ptime_d, last: 1'b0};
            n         = n + 2'd1;
          end
          open_d = 1'b0;
        end
        phase_d    = PH_HUNT;
        magic_lo_d = 1'b0;
        hcnt_d     = '0;
      end
    end

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign res_cnt_o = en_i ? n : 2'd0;
  assign res0_o    = res[0];
  assign res1_o    = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      magic_lo_q <= 1'b0;
      hcnt_q     <= '0;
      left_q     <= '0;
      pkind_q    <= '0;
      ptime_q    <= '0;
      prev_id_q  <= '0;
      id_seen_q  <= 1'b0;
      open_q     <= 1'b0;
      bad_q      <= 1'b0;
    end else if (en_i) begin
      phase_q    <= phase_d;
      magic_lo_q <= magic_lo_d;
      hcnt_q     <= hcnt_d;
      left_q     <= left_d;
      pkind_q    <= pkind_d;
      ptime_q    <= ptime_d;
      prev_id_q  <= prev_id_d;
      id_seen_q  <= id_seen_d;
      open_q     <= open_d;
      bad_q      <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !mode_i) begin
      if (hdr_we) begin
        hdr_q[hdr_idx] <= hdr_wdata;
      end
      if (magic_we) begin
        hdr_q[0] <= cfg_i.magic_word[7:0];
        hdr_q[1] <= cfg_i.magic_word[15:8];
      end
    end
  end

endmodule

// ===== sv/dpd_res_fifo.sv =====
// Four-entry result queue of the depth packet deframer; takes up to two items a cycle.
// Drives the output channel. Depends on dpd_pkg.
module dpd_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  dpd_pkg::result_t push0_i,
  input  dpd_pkg::result_t push1_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dpd_pkg::result_t head_o
);
  import dpd_pkg::*;

  result_t    mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rptr_q];
  assign room_o      = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + push_cnt_i;
      rptr_q <= rptr_q + {1'b0, pop};
      cnt_q  <= cnt_q + {1'b0, push_cnt_i} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= push1_i;
    end
  end

endmodule

// ===== sv/depth_packet_deframer.sv =====
// Depth packet deframer top level: input register, byte parser and result queue.
// Depends on dpd_pkg, dpd_parse and dpd_res_fifo.
//
// Takes one stream byte or packet-lost event per cycle from a registered input
// stage. The parser finds the magic word, decodes the header and emits frame
// start, frame data and frame complete items; one byte can give up to two items.
// Items leave through a four-entry queue at one per cycle while the consumer is
// ready. The input stage advances only while the queue holds two items or
// fewer, so a steady stream runs at one byte per cycle whenever the consumer
// keeps up. Configuration writes take effect at once and are meant for idle
// periods.
module depth_packet_deframer #(
  parameter int HEADER_BYTES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  frame_byte_o,
  output logic [31:0] frame_time_o,
  output logic        last_o
);
  import dpd_pkg::*;

  cfg_t       cfg_q;
  logic       s_valid_q;
  logic       s_mode_q;
  logic [7:0] s_byte_q;
  logic       room;
  logic       advance;
  logic [1:0] res_cnt;
  result_t    res0, res1, head;

  assign advance    = s_valid_q && room;
  assign in_ready_o = !s_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word <= 16'd16978;
      cfg_q.start_type <= 16'd28928;
      cfg_q.end_type   <= 16'd29952;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC:      cfg_q.magic_word <= cfg_wdata_i;
        CFG_START_TYPE: cfg_q.start_type <= cfg_wdata_i;
        CFG_END_TYPE:   cfg_q.end_type   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_mode_q <= mode_i;
      s_byte_q <= data_byte_i;
    end
  end

  dpd_parse #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .mode_i      (s_mode_q),
    .data_byte_i (s_byte_q),
    .cfg_i       (cfg_q),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  dpd_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (res_cnt),
    .push0_i     (res0),
    .push1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign frame_byte_o = head.frame_byte;
  assign frame_time_o = head.frame_time;
  assign last_o       = head.last;

endmodule

// ===== tb/depth_packet_deframer_tb.sv =====
// Self-checking testbench for depth_packet_deframer: packet streams with random content,
// noise, lost packets and broken headers, checked against a cycle-free predictor.
// Depends on dpd_pkg and the depth_packet_deframer RTL only.
module depth_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int HDR_LEN       = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_style_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_MAGIC;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        mode_i      = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  frame_byte_o;
  logic [31:0] frame_time_o;
  logic        last_o;

  class deframe_scoreboard;
    cfg_t        cfg;
    phase_e      phase;
    bit          magic_lo_seen;
    int          hdr_count;
    logic [7:0]  hdr [HDR_LEN];
    logic [15:0] payload_left;
    logic [15:0] pkt_type;
    logic [31:0] pkt_time;
    logic [15:0] last_id;
    bit          id_valid;
    bit          frame_open;
    bit          frame_bad;
    result_t     fresh[$];
    result_t     due_results[$];
    int          errors;

    function new();
      cfg.magic_word = 16'd16978;
      cfg.start_type = 16'd28928;
      cfg.end_type   = 16'd29952;
      hunt();
      payload_left = '0;
      pkt_type     = '0;
      pkt_time     = '0;
      last_id      = '0;
      id_valid     = 1'b0;
      frame_open   = 1'b0;
      frame_bad    = 1'b0;
      errors       = 0;
    endfunction

    function void hunt();
      phase         = PH_HUNT;
      magic_lo_seen = 1'b0;
      hdr_count     = 0;
    endfunction

    function void add(kind_e k, logic [7:0] b, logic [31:0] t);
      result_t r;
      r.kind       = k;
      r.frame_byte = b;
      r.frame_time = t;
      r.last       = 1'b0;
      fresh = {fresh, r};
    endfunction

    function void close_packet();
      if (pkt_type == cfg.end_type) begin
        if (frame_open && !frame_bad) add(KIND_DONE, 8'h00, pkt_time);
        frame_open = 1'b0;
      end
      hunt();
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function void decode_input(logic m, logic [7:0] b);
      logic [15:0] id;
      logic [15:0] size;
      logic [15:0] id_next;
      fresh.delete();
      if (m) begin
        frame_bad = 1'b1;
        hunt();
        return;
      end
      case (phase)
        PH_HEADER: begin
          hdr[hdr_count] = b;
          hdr_count++;
          if (hdr_count >= HDR_LEN) begin
            pkt_type = {hdr[3], hdr[2]};
            id       = {hdr[5], hdr[4]};
            size     = {hdr[6], hdr[7]};
            pkt_time = {hdr[11], hdr[10], hdr[9], hdr[8]};
            if (size < HDR_LEN) begin
              frame_bad = 1'b1;
              hunt();
            end else begin
              id_next = last_id + 16'd1;
              if (id_valid && id != id_next) frame_bad = 1'b1;
              last_id  = id;
              id_valid = 1'b1;
              if (pkt_type == cfg.start_type) begin
                frame_open = 1'b1;
                frame_bad  = 1'b0;
                add(KIND_START, 8'h00, 32'h0);
              end
              payload_left = size - 16'(HDR_LEN);
              phase        = PH_PAYLOAD;
              if (payload_left == 0) close_packet();
            end
          end
        end
        PH_PAYLOAD: begin
          if (frame_open && !frame_bad) add(KIND_DATA, b, 32'h0);
          if (payload_left > 0) payload_left--;
          if (payload_left == 0) close_packet();
        end
        default: begin
          if (magic_lo_seen && b == cfg.magic_word[15:8]) begin
            magic_lo_seen = 1'b0;
            hdr[0]        = cfg.magic_word[7:0];
            hdr[1]        = cfg.magic_word[15:8];
            hdr_count     = 2;
            phase         = PH_HEADER;
          end else begin
            phase         = PH_HUNT;
            magic_lo_seen = (b == cfg.magic_word[7:0]);
          end
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      due_results = {due_results, fresh};
    endfunction

    function void compare_result(logic [1:0] k, logic [7:0] b, logic [31:0] t, logic l);
      result_t want;
      if (due_results.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: kind %0d byte %02h time %08h last %0d", k, b, t, l);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (k !== want.kind || b !== want.frame_byte || t !== want.frame_time ||
          l !== want.last) begin
        if (errors < 10)
          $display("mismatch: kind %0d/%0d byte %02h/%02h time %08h/%08h last %0d/%0d",
                   want.kind, k, want.frame_byte, b, want.frame_time, t, want.last, l);
        errors++;
      end
    endfunction
  endclass

  deframe_scoreboard sb;
  int          burst_left = 0;
  int          items_sent = 0;
  int          hold_reqs  = 0;
  logic [15:0] next_id    = 16'h0000;

  depth_packet_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .frame_byte_o(frame_byte_o),
    .frame_time_o(frame_time_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.decode_input(mode_i, data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.compare_result(kind_o, frame_byte_o, frame_time_o, last_o);
    end
  end

  initial begin
    int        cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("depth_packet_deframer verification failed");
    $finish;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int        rx_cycle;
    int        served;
    rx_style_e style;
    rx_cycle = 0;
    served   = 0;
    style    = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != served) begin
        served = hold_reqs;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rx_cycle++;
      if (rx_cycle % 300 == 0) style = rx_style_e'($urandom_range(0, 3));
      case (style)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 9) != 0);
        default:   out_ready_i <= (rx_cycle % 7 < 3);
      endcase
    end
  end

  task automatic send_item(logic m, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [15:0] magic, logic [15:0] st, logic [15:0] et);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MAGIC;
    cfg_wdata_i <= magic;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_START_TYPE;
    cfg_wdata_i <= st;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_END_TYPE;
    cfg_wdata_i <= et;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.cfg.magic_word = magic;
    sb.cfg.start_type = st;
    sb.cfg.end_type   = et;
  endtask

  // cut > 0 and below the packet length: stop after that many bytes and report the packet lost
  task automatic send_packet(logic [15:0] ptype, logic [15:0] size, int cut);
    logic [7:0]  pkt[$];
    logic [31:0] stamp;
    int          stop;
    stamp = $urandom();
    pkt = {sb.cfg.magic_word[7:0], sb.cfg.magic_word[15:8], ptype[7:0], ptype[15:8],
           next_id[7:0], next_id[15:8], size[15:8], size[7:0],
           stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24]};
    if (size >= HDR_LEN) repeat (int'(size) - HDR_LEN) pkt = {pkt, 8'($urandom())};
    stop = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < stop; i++) send_item(1'b0, pkt[i]);
    if (stop < pkt.size()) send_item(1'b1, 8'($urandom()));
    if (size >= HDR_LEN && stop >= HDR_LEN) next_id++;
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(12, 32));
    if (r < 97) return 16'($urandom_range(33, 80));
    return 16'($urandom_range(81, 300));
  endfunction

  function automatic logic [15:0] pick_type();
    case ($urandom_range(0, 2))
      0:       return sb.cfg.start_type;
      1:       return sb.cfg.end_type;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_frame();
    int extra;
    extra = $urandom_range(0, 3);
    send_packet(sb.cfg.start_type, pick_size(), 0);
    repeat (extra) begin
      if ($urandom_range(0, 15) == 0) next_id += 16'($urandom_range(2, 50));
      send_packet(16'($urandom()), pick_size(),
                  ($urandom_range(0, 15) == 0) ? $urandom_range(1, 20) : 0);
    end
    send_packet(sb.cfg.end_type, pick_size(), 0);
  endtask

  task automatic run_traffic(int n);
    int goal;
    int pick;
    goal = items_sent + n;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) send_frame();
      else if (pick < 75) send_packet(pick_type(), pick_size(), 0);
      else if (pick < 83)
        repeat ($urandom_range(1, 8))
          send_item(1'b0, ($urandom_range(0, 3) == 0) ? sb.cfg.magic_word[7:0]
                                                      : 8'($urandom()));
      else if (pick < 88) send_item(1'b1, 8'($urandom()));
      else if (pick < 93) send_packet(pick_type(), 16'($urandom_range(0, 11)), 0);
      else if (pick < 97) send_packet(pick_type(), pick_size(), $urandom_range(1, 30));
      else if (pick < 99) next_id += 16'($urandom_range(2, 1000));
      else settle();
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: lost event, byte extremes, empty start packet, id wrap to zero
    next_id = 16'hFFFF;
    send_item(1'b1, 8'h5A);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_packet(sb.cfg.start_type, 16'd12, 0);
    send_packet(sb.cfg.end_type, 16'd13, 0);
    settle();

    write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(250);
    settle();

    write_cfg(16'h0000, 16'h0000, 16'h0001);
    run_traffic(250);
    settle();

    write_cfg(16'($urandom()), 16'($urandom()), 16'($urandom()));
    hold_reqs <= hold_reqs + 1;
    run_traffic(400);
    settle();

    write_cfg(16'd16978, 16'd28928, 16'd29952);
    hold_reqs <= hold_reqs + 1;
    run_traffic(300);
    send_packet(pick_type(), 16'hFFFF, 40);
    run_traffic(200);
    settle();

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("depth_packet_deframer verification clean");
    end else begin
      $display("depth_packet_deframer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dpd_pkg.sv
sv/dpd_parse.sv
sv/dpd_res_fifo.sv
sv/depth_packet_deframer.sv
tb/depth_packet_deframer_tb.sv
